/* rtl/i4gsdp_pkg.sv */
// Package for the int4 group scaled dot product block.
// Payload structs, reset constants, register indexes and fp32 helper functions.
// No dependencies.
package i4gsdp_pkg;

    localparam int GroupSizeDefault = 128;
    localparam int LanesDefault     = 8;
    localparam int MaxLanesUsed     = 8;
    localparam int ProdW            = 12;

    localparam logic [31:0] ActScaleReset  = 32'h3F80_0000;
    localparam logic [10:0] GroupsReset    = 11'd40;
    localparam logic [18:0] RowCountReset  = 19'd10240;
    localparam logic [10:0] MaxGroups      = 11'd1024;
    localparam logic [18:0] MaxRows        = 19'd262144;

    localparam logic [31:0] FpDefaultNan   = 32'hFFC0_0000;
    localparam logic [31:0] FpQuietBit     = 32'h0040_0000;

    typedef enum logic [1:0] {
        REG_ACT_SCALE  = 2'd0,
        REG_GROUPS     = 2'd1,
        REG_ROW_COUNT  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [31:0] packed_weights;
        logic [31:0] act_low;
        logic [31:0] act_high;
        logic [15:0] group_scale;
    } t_in_item;

    typedef struct packed {
        logic [31:0] row_result;
        logic        last_row;
    } t_out_item;

    // Unrounded operation result: value = sig * 2^exp, or a ready special code.
    typedef struct packed {
        logic               special;
        logic [31:0]        special_val;
        logic               sign;
        logic signed [11:0] exp;
        logic [47:0]        sig;
    } t_fp_raw;

    function automatic logic fp_is_nan(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [7:0] fp_eff_exp(logic [31:0] a);
        return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    endfunction

    function automatic logic [23:0] fp_mant(logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic t_fp_raw fp_mul_raw(logic [31:0] a, logic [31:0] b);
        t_fp_raw r;
        r = '0;
        r.sign = a[31] ^ b[31];
        if (fp_is_nan(a)) begin
            r.special = 1'b1;
            r.special_val = a | FpQuietBit;
        end else if (fp_is_nan(b)) begin
            r.special = 1'b1;
            r.special_val = b | FpQuietBit;
        end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
            r.special = 1'b1;
            r.special_val = FpDefaultNan;
        end else if (fp_is_inf(a) || fp_is_inf(b)) begin
            r.special = 1'b1;
            r.special_val = {a[31] ^ b[31], 8'hFF, 23'd0};
        end else begin
            r.exp = 12'(signed'({4'd0, fp_eff_exp(a)})) + 12'(signed'({4'd0, fp_eff_exp(b)}))
                    - 12'sd300;
            r.sig = 48'(fp_mant(a)) * 48'(fp_mant(b));
        end
        return r;
    endfunction

    function automatic t_fp_raw fp_add_raw(logic [31:0] a, logic [31:0] b);
        t_fp_raw     r;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  d;
        logic [4:0]  dd;
        logic [53:0] yext;
        logic [26:0] xs;
        logic [26:0] ys;
        logic [27:0] s;
        r = '0;
        x = (a[30:0] >= b[30:0]) ? a : b;
        y = (a[30:0] >= b[30:0]) ? b : a;
        d = fp_eff_exp(x) - fp_eff_exp(y);
        dd = (d > 8'd27) ? 5'd27 : d[4:0];
        yext = {fp_mant(y), 3'b000, 27'd0} >> dd;
        xs = {fp_mant(x), 3'b000};
        ys = {yext[53:28], yext[27] | (|yext[26:0])};
        s = (x[31] ^ y[31]) ? (28'(xs) - 28'(ys)) : (28'(xs) + 28'(ys));
        if (fp_is_nan(a)) begin
            r.special = 1'b1;
            r.special_val = a | FpQuietBit;
        end else if (fp_is_nan(b)) begin
            r.special = 1'b1;
            r.special_val = b | FpQuietBit;
        end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
            r.special = 1'b1;
            r.special_val = FpDefaultNan;
        end else if (fp_is_inf(a) || fp_is_inf(b)) begin
            r.special = 1'b1;
            r.special_val = fp_is_inf(a) ? a : b;
        end else begin
            r.sign = (s == 28'd0) ? (a[31] & b[31]) : x[31];
            r.exp = 12'(signed'({4'd0, fp_eff_exp(x)})) - 12'sd153;
            r.sig = 48'(s);
        end
        return r;
    endfunction

    // Normalize, round to nearest even, pack; handles subnormal and overflow.
    function automatic logic [31:0] fp_round(t_fp_raw r);
        logic [5:0]         lead;
        logic signed [12:0] e_norm;
        logic signed [12:0] e_eff;
        logic signed [12:0] rs;
        logic [5:0]         shamt;
        logic [96:0]        ext;
        logic [47:0]        q;
        logic               rnd;
        logic               stk;
        logic [24:0]        q2;
        logic [31:0]        res;
        lead = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r.sig[i]) lead = 6'(i);
        end
        e_norm = 13'(r.exp) + 13'(signed'({1'b0, lead})) + 13'sd127;
        e_eff = (e_norm < 13'sd1) ? 13'sd1 : e_norm;
        rs = 13'(signed'({1'b0, lead})) - 13'sd23 + (e_eff - e_norm);
        ext = '0;
        if (rs < 13'sd0) begin
            q = r.sig << 6'(-rs);
            rnd = 1'b0;
            stk = 1'b0;
        end else begin
            shamt = (rs > 13'sd49) ? 6'd49 : 6'(rs);
            ext = {r.sig, 49'd0} >> shamt;
            q = ext[96:49];
            rnd = ext[48];
            stk = |ext[47:0];
        end
        q2 = 25'(q[23:0]) + 25'(rnd & (stk | q[0]));
        if (q2[24]) begin
            q2 = q2 >> 1;
            e_eff = e_eff + 13'sd1;
        end
        if (r.special) begin
            res = r.special_val;
        end else if (r.sig == 48'd0) begin
            res = {r.sign, 31'd0};
        end else if (e_eff >= 13'sd255) begin
            res = {r.sign, 8'hFF, 23'd0};
        end else if (!q2[23]) begin
            res = {r.sign, 8'h00, q2[22:0]};
        end else begin
            res = {r.sign, e_eff[7:0], q2[22:0]};
        end
        return res;
    endfunction

endpackage

/* rtl/i4gsdp_lane.sv */
// One multiply lane: signed 4-bit weight times signed 8-bit activation.
// Uses i4gsdp_pkg for the product width.
module i4gsdp_lane (
    input  logic [3:0]                        i_weight,
    input  logic [7:0]                        i_act,
    output logic signed [i4gsdp_pkg::ProdW-1:0] o_prod
);
    import i4gsdp_pkg::*;

    logic signed [ProdW-1:0] w_ext;
    logic signed [ProdW-1:0] a_ext;

    assign w_ext  = ProdW'(signed'(i_weight));
    assign a_ext  = ProdW'(signed'(i_act));
    assign o_prod = w_ext * a_ext;

endmodule

/* rtl/i4gsdp_fold.sv */
// Group fold sequencer: int to fp32, two scale multiplies, row accumulate,
// result register. Uses the fp32 helpers of i4gsdp_pkg.
module i4gsdp_fold #(
    parameter int SUM_W = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [15:0]             i_wscale,
    input  logic [31:0]             i_ascale,
    input  logic                    i_row_end,
    input  logic                    i_last,
    input  logic                    i_out_stall,
    output logic                    o_busy,
    output logic                    o_out_valid,
    output i4gsdp_pkg::t_out_item   o_out_data
);
    import i4gsdp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RAW, S_RND, S_OUT} t_state;
    typedef enum logic [1:0] {OP_CONV, OP_SCALE, OP_ASCALE, OP_ACC} t_op;

    t_state              r_state;
    t_op                 r_op;
    logic signed [SUM_W-1:0] r_sum;
    logic [15:0]         r_wscale;
    logic                r_row_end;
    logic                r_last;
    t_fp_raw             r_raw;
    logic [31:0]         r_t;
    logic [31:0]         r_acc;
    logic                r_out_valid;
    t_out_item           r_out_data;

    t_fp_raw             n_raw;
    logic [31:0]         n_rounded;
    logic [SUM_W-1:0]    sum_mag;
    logic                out_free;

    assign sum_mag   = r_sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(r_sum)) : SUM_W'(r_sum);
    assign n_rounded = fp_round(r_raw);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_raw = '0;
        case (r_op)
            OP_CONV: begin
                n_raw.sign = r_sum[SUM_W-1];
                n_raw.sig  = 48'(sum_mag);
            end
            OP_SCALE:  n_raw = fp_mul_raw(r_t, {r_wscale, 16'd0});
            OP_ASCALE: n_raw = fp_mul_raw(r_t, i_ascale);
            OP_ACC:    n_raw = fp_add_raw(r_acc, r_t);
            default:   n_raw = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CONV;
            r_acc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sum     <= i_sum;
                        r_wscale  <= i_wscale;
                        r_row_end <= i_row_end;
                        r_last    <= i_last;
                        r_op      <= OP_CONV;
                        r_state   <= S_RAW;
                    end
                end
                S_RAW: begin
                    r_raw   <= n_raw;
                    r_state <= S_RND;
                end
                S_RND: begin
                    case (r_op)
                        OP_CONV: begin
                            r_t     <= n_rounded;
                            r_op    <= OP_SCALE;
                            r_state <= S_RAW;
                        end
                        OP_SCALE: begin
                            r_t     <= n_rounded;
                            r_op    <= OP_ASCALE;
                            r_state <= S_RAW;
                        end
                        OP_ASCALE: begin
                            r_t     <= n_rounded;
                            r_op    <= OP_ACC;
                            r_state <= S_RAW;
                        end
                        default: begin
                            r_acc   <= n_rounded;
                            r_state <= r_row_end ? S_OUT : S_IDLE;
                        end
                    endcase
                end
                S_OUT: begin
                    // hold the finished row until the result register frees up
                    if (out_free) begin
                        r_out_data.row_result <= r_acc;
                        r_out_data.last_row   <= r_last;
                        r_acc                 <= 32'd0;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_RAW && r_op == OP_CONV))
        else $error("fold did not start on request");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_acc == 32'd0))
        else $error("row result not loaded or accumulator not cleared");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && r_state != S_OUT) |=> !r_out_valid)
        else $error("result valid without a finished row");

    a_acc_only_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_op == OP_ACC && !r_row_end) |=> (r_state == S_IDLE))
        else $error("mid-row fold did not return to idle");

endmodule

/* rtl/int4_group_scaled_dot_product_top.sv */
// Top level of the int4 group scaled dot product block.
// Instantiates i4gsdp_lane and i4gsdp_fold; uses i4gsdp_pkg.
//
// Input channel: i_in_valid / o_in_stall / i_in_data, one transaction per item
// of eight int4 weights and eight int8 activations plus the group's bf16 scale.
// Output channel: o_out_valid / i_out_stall / o_out_data, one transaction per
// finished matrix row (fp32 row result and a last-row flag).
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (activation scale,
// groups per row, row count). Users write only while the block is idle (not enforced).
//
// Throughput: an item is taken every cycle inside a group; the lanes and the
// lane adder fold one item per cycle into the group sum. The item that closes a
// group starts the fp32 sequencer (convert, two multiplies, add, each a raw
// state then a round state) and the input stalls while the sequencer is busy.
// After the add that closes a row, the sequencer moves to S_OUT and loads the row
// result into the output register. If the receiver stalls while a previous
// result is still held, the sequencer waits and the input stays stalled until
// it is taken.
// Reset clears counters, the group sum, the accumulator (+0.0) and the result
// valid, and loads the register defaults.
module int4_group_scaled_dot_product_top #(
    parameter int GROUP_SIZE = i4gsdp_pkg::GroupSizeDefault,
    parameter int LANES      = i4gsdp_pkg::LanesDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i4gsdp_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i4gsdp_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import i4gsdp_pkg::*;

    localparam int ITEMS   = GROUP_SIZE / LANES;
    localparam int IW      = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int SUM_W   = $clog2(GROUP_SIZE) + 12;
    localparam int NLANES  = (LANES < MaxLanesUsed) ? LANES : MaxLanesUsed;
    localparam int DOT_W   = ProdW + 3;

    logic [31:0]             r_act_scale;
    logic [10:0]             r_groups;
    logic [18:0]             r_row_count;
    logic signed [SUM_W-1:0] r_group_sum;
    logic [IW-1:0]           r_item;
    logic [9:0]              r_group;
    logic [17:0]             r_row;

    logic signed [ProdW-1:0] prod [NLANES];
    logic signed [DOT_W-1:0] dot;
    logic signed [SUM_W-1:0] sum_next;
    logic                    accept;
    logic                    group_end;
    logic                    row_end;
    logic                    last;
    logic [10:0]             gpr_eff;
    logic [18:0]             rc_eff;
    logic                    busy;

    genvar g;
    generate
        for (g = 0; g < NLANES; g++) begin : g_lane
            logic [31:0] act_word;
            assign act_word = (g < 4) ? i_in_data.act_low : i_in_data.act_high;
            i4gsdp_lane u_lane (
                .i_weight (i_in_data.packed_weights[4*g +: 4]),
                .i_act    (act_word[8*(g%4) +: 8]),
                .o_prod   (prod[g])
            );
        end
    endgenerate

    // merge the lane products
    always_comb begin
        dot = '0;
        for (int i = 0; i < NLANES; i++) begin
            dot = dot + DOT_W'(prod[i]);
        end
    end

    assign sum_next  = r_group_sum + SUM_W'(dot);
    assign accept    = i_in_valid && !o_in_stall;
    assign group_end = r_item == IW'(ITEMS - 1);
    assign gpr_eff   = (r_groups == 11'd0) ? 11'd1 :
                       (r_groups > MaxGroups) ? MaxGroups : r_groups;
    assign rc_eff    = (r_row_count == 19'd0) ? 19'd1 :
                       (r_row_count > MaxRows) ? MaxRows : r_row_count;
    assign row_end   = (11'(r_group) + 11'd1) >= gpr_eff;
    assign last      = (19'(r_row) + 19'd1) >= rc_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_scale <= ActScaleReset;
            r_groups    <= GroupsReset;
            r_row_count <= RowCountReset;
            r_group_sum <= '0;
            r_item      <= '0;
            r_group     <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACT_SCALE: r_act_scale <= i_cfg_data;
                    REG_GROUPS:    r_groups    <= i_cfg_data[10:0];
                    REG_ROW_COUNT: r_row_count <= i_cfg_data[18:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (group_end) begin
                    r_group_sum <= '0;
                    r_item      <= '0;
                    if (row_end) begin
                        r_group <= '0;
                        r_row   <= last ? 18'd0 : r_row + 18'd1;
                    end else begin
                        r_group <= r_group + 10'd1;
                    end
                end else begin
                    r_group_sum <= sum_next;
                    r_item      <= r_item + IW'(1);
                end
            end
        end
    end

    i4gsdp_fold #(.SUM_W(SUM_W)) u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && group_end),
        .i_sum       (sum_next),
        .i_wscale    (i_in_data.group_scale),
        .i_ascale    (r_act_scale),
        .i_row_end   (row_end),
        .i_last      (last),
        .i_out_stall (i_out_stall),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = busy;

endmodule

/* tb/group_dot_checker.sv */
// Checker for the int4 group scaled dot product block: predicts row results
// from the accepted input and configuration transactions and compares outputs.
// Depends on i4gsdp_pkg for the payload types and register indexes.
module group_dot_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  i4gsdp_pkg::t_in_item  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  i4gsdp_pkg::t_out_item i_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    import i4gsdp_pkg::t_in_item;
    import i4gsdp_pkg::t_out_item;
    import i4gsdp_pkg::t_reg_index;
    import i4gsdp_pkg::REG_ACT_SCALE;
    import i4gsdp_pkg::REG_GROUPS;
    import i4gsdp_pkg::REG_ROW_COUNT;

    localparam int          ItemsPerGroup = 16;
    localparam logic [31:0] QuietBit      = 32'h0040_0000;
    localparam logic [31:0] DefaultNan    = 32'hFFC0_0000;

    logic [31:0] act_scale;
    logic [10:0] groups_cfg;
    logic [18:0] rows_cfg;
    int          group_acc;
    int          items_seen;
    int          groups_seen;
    int          row_idx;
    logic [31:0] row_acc;
    t_out_item   expected_rows[$];

    function automatic logic is_nan(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    function automatic logic is_inf(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] == 0;
    endfunction

    function automatic logic [23:0] mant_of(logic [31:0] a);
        return {a[30:23] != 0, a[22:0]};
    endfunction

    function automatic int scale_of(logic [31:0] a);
        return (a[30:23] == 0 ? 1 : int'(a[30:23])) - 150;
    endfunction

    // value = mag * 2^scl, rounded to nearest even into binary32
    function automatic logic [31:0] round_to_f32(logic sgn, logic [63:0] mag, int scl);
        int           p;
        int           biased;
        int           sh;
        logic [127:0] ext;
        logic [63:0]  q;
        logic         rb;
        logic         sb;
        if (mag == 0) return {sgn, 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) p = i;
        biased = p + scl + 127;
        sh = (biased < 1) ? -149 - scl : p - 23;
        if (sh < 0) begin
            q = mag << (-sh);
            rb = 1'b0;
            sb = 1'b0;
        end else begin
            if (sh > 100) sh = 100;
            ext = {mag, 64'd0} >> sh;
            q = ext[127:64];
            rb = ext[63];
            sb = |ext[62:0];
        end
        q = q + 64'(rb & (sb | q[0]));
        if (biased < 1) return {sgn, 7'd0, q[23], q[22:0]};
        if (q[24]) begin
            q = q >> 1;
            biased++;
        end
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(biased), q[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        if (is_nan(a)) return a | QuietBit;
        if (is_nan(b)) return b | QuietBit;
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return DefaultNan;
        if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
        return round_to_f32(a[31] ^ b[31], 64'(mant_of(a)) * 64'(mant_of(b)),
                            scale_of(a) + scale_of(b));
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [63:0] big;
        logic [63:0] sml;
        logic [63:0] s;
        int          d;
        int          scl;
        if (is_nan(a)) return a | QuietBit;
        if (is_nan(b)) return b | QuietBit;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DefaultNan;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        x = (a[30:0] >= b[30:0]) ? a : b;
        y = (a[30:0] >= b[30:0]) ? b : a;
        d = scale_of(x) - scale_of(y);
        // a far smaller operand only matters as a sticky bit
        if (d <= 30) begin
            big = 64'(mant_of(x)) << d;
            sml = 64'(mant_of(y));
            scl = scale_of(y);
        end else begin
            big = 64'(mant_of(x)) << 30;
            sml = (y[30:0] == 0) ? 64'd0 : 64'd1;
            scl = scale_of(x) - 30;
        end
        s = (x[31] ^ y[31]) ? big - sml : big + sml;
        if (s == 0) return {a[31] & b[31], 31'd0};
        return round_to_f32(x[31], s, scl);
    endfunction

    function automatic int lane_dot(t_in_item it);
        int sum;
        logic [63:0] acts;
        sum = 0;
        acts = {it.act_high, it.act_low};
        for (int i = 0; i < 8; i++)
            sum += int'($signed(it.packed_weights[4*i +: 4])) * int'($signed(acts[8*i +: 8]));
        return sum;
    endfunction

    task automatic fold_item(t_in_item it);
        logic [31:0] t;
        int          gpr;
        int          rc;
        logic        last;
        group_acc += lane_dot(it);
        items_seen++;
        if (items_seen < ItemsPerGroup) return;
        t = round_to_f32(group_acc < 0, 64'(group_acc < 0 ? -group_acc : group_acc), 0);
        t = f32_mul(t, {it.group_scale, 16'h0000});
        t = f32_mul(t, act_scale);
        row_acc = f32_add(row_acc, t);
        group_acc = 0;
        items_seen = 0;
        gpr = (groups_cfg == 0) ? 1 : (groups_cfg > 1024 ? 1024 : int'(groups_cfg));
        if (groups_seen + 1 < gpr) begin
            groups_seen++;
            return;
        end
        groups_seen = 0;
        rc = (rows_cfg == 0) ? 1 : (rows_cfg > 262144 ? 262144 : int'(rows_cfg));
        last = (row_idx + 1 >= rc);
        expected_rows.push_back('{row_result: row_acc, last_row: last});
        row_idx = last ? 0 : row_idx + 1;
        row_acc = 32'd0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            act_scale = 32'h3F80_0000;
            groups_cfg = 11'd40;
            rows_cfg = 19'd10240;
            group_acc = 0;
            items_seen = 0;
            groups_seen = 0;
            row_idx = 0;
            row_acc = 32'd0;
            expected_rows.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_ACT_SCALE: act_scale = i_cfg_data;
                    REG_GROUPS:    groups_cfg = i_cfg_data[10:0];
                    REG_ROW_COUNT: rows_cfg = i_cfg_data[18:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row result %h", i_out_data.row_result);
                    errs++;
                end else begin
                    want = expected_rows.pop_front();
                    if (want.row_result !== i_out_data.row_result) begin
                        $error("row_result: expected %h, actual %h",
                               want.row_result, i_out_data.row_result);
                        errs++;
                    end
                    if (want.last_row !== i_out_data.last_row) begin
                        $error("last_row: expected %b, actual %b",
                               want.last_row, i_out_data.last_row);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) fold_item(i_in_data);
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_rows.size();
    end
endmodule

/* tb/testbench.sv */
// Top of the testbench for int4_group_scaled_dot_product_top: clock, reset,
// stimulus with random idling, and the verdict.
// Depends on i4gsdp_pkg, the block and group_dot_checker.
module testbench;
    import i4gsdp_pkg::t_in_item;
    import i4gsdp_pkg::t_out_item;
    import i4gsdp_pkg::t_reg_index;
    import i4gsdp_pkg::REG_ACT_SCALE;
    import i4gsdp_pkg::REG_GROUPS;
    import i4gsdp_pkg::REG_ROW_COUNT;

    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    logic        quiet;
    logic        hold_req;

    int_dummy_guard: assert property (@(posedge i_clk) 1);

    int4_group_scaled_dot_product_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    group_dot_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (300) @(negedge i_clk);
                out_stall = 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(t_reg_index idx, logic [31:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // wait for every row in flight, then for the fold sequencer to settle
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.packed_weights = $urandom;
        it.act_low = $urandom;
        it.act_high = $urandom;
        if ($urandom_range(0, 15) == 0)
            it.group_scale = 16'($urandom);
        else
            it.group_scale = {1'($urandom), 8'(118 + $urandom_range(0, 16)), 7'($urandom)};
        return it;
    endfunction

    function automatic logic [31:0] pick_act_scale();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7F80_0000;
            2: return 32'h7FC0_1234;
            3: return 32'h0000_0001;
            4: return 32'h7F7F_FFFF;
            5: return $urandom;
            6: return 32'h3F80_0000;
            default: return {1'($urandom), 8'(120 + $urandom_range(0, 14)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] pick_groups();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd2;
            2: return 32'd3;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [31:0] pick_rows();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd262144;
            3: return 32'h7FFFF;
            4: return 32'($urandom_range(2, 6));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ACT_SCALE;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // extremes at reset scale, one group per row, row count of two
        write_reg(REG_GROUPS, 32'd1);
        write_reg(REG_ROW_COUNT, 32'd2);
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0: it = '{32'h8888_8888, 32'h8080_8080, 32'h8080_8080, 16'h3F80};
                1: it = '{32'h7777_7777, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'hBF80};
                2: it = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0080};
                default: it = '{32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 16'h7F80};
            endcase
            send_item(it);
        end
        drain();

        // oversized group count, then shrink it mid-row so the next group ends the row
        write_reg(REG_GROUPS, 32'h7FF);
        for (int i = 0; i < 32; i++) send_item(random_item());
        drain();
        write_reg(REG_GROUPS, 32'd1);
        for (int i = 0; i < 16; i++) send_item(random_item());
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            quiet = (ph == 10);
            write_reg(REG_ACT_SCALE, pick_act_scale());
            write_reg(REG_GROUPS, pick_groups());
            write_reg(REG_ROW_COUNT, pick_rows());
            for (int i = 0; i < 150; i++) begin
                if (ph == 3 && i == 10) hold_req = 1'b1;
                send_item(random_item());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/i4gsdp_pkg.sv
rtl/i4gsdp_lane.sv
rtl/i4gsdp_fold.sv
rtl/int4_group_scaled_dot_product_top.sv
tb/group_dot_checker.sv
tb/testbench.sv
